// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define RBB_ASSERT_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blur checker: property failed");

// Checked at every edge, reset included.
`define RBB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("blur checker: property failed");

`endif

// File: hdl/rbb_pkg.sv
// Types and constants shared by the 3x3 box blur modules.
package rbb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 3 * CH_W;
  localparam int unsigned SUM_W     = $clog2(9 * (2 ** CH_W - 1) + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic MODE_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // Number of in-frame neighbors that the window sum covers.
  typedef enum logic [1:0] {
    CNT_FOUR = 2'd0,
    CNT_SIX  = 2'd1,
    CNT_NINE = 2'd2
  } cnt_code_t;

  // Which sides of the output pixel lie inside the frame, and whether it ends the frame.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
    logic frame_end;
  } nbr_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    cnt_code_t        cnt;
    logic             frame_end;
  } sum_t;

endpackage

// File: hdl/rbb_if.sv
// Channel interfaces of the blur block: pixel input, blurred output, configuration.
interface rbb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [rbb_pkg::CH_W-1:0]  pixel_red;
  logic [rbb_pkg::CH_W-1:0]  pixel_green;
  logic [rbb_pkg::CH_W-1:0]  pixel_blue;

  modport source (output valid, mode, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, mode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rbb_out_if;
  logic                      valid;
  logic                      ready;
  logic [rbb_pkg::CH_W-1:0]  blur_red;
  logic [rbb_pkg::CH_W-1:0]  blur_green;
  logic [rbb_pkg::CH_W-1:0]  blur_blue;
  logic                      frame_end;

  modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
  modport sink   (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

interface rbb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rbb_pkg::CFG_IDX_W-1:0] index;
  logic [rbb_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/rbb_line_store.sv
// Two line memories holding the previous two rows, with write-back forwarding.
module rbb_line_store #(
  parameter int unsigned DEPTH  = rbb_pkg::MAX_WIDTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  rbb_pkg::pixel_t       wr_px,
  input  logic                  wb_en,
  input  logic [ADDR_W-1:0]     wb_addr,
  output rbb_pkg::pixel_t       top_px,
  output rbb_pkg::pixel_t       mid_px
);

  rbb_pkg::pixel_t prev_mem  [DEPTH];
  rbb_pkg::pixel_t prev2_mem [DEPTH];

  rbb_pkg::pixel_t prev_rd_r;
  rbb_pkg::pixel_t prev2_rd_r;
  rbb_pkg::pixel_t fwd_px_r;
  logic            fwd_r;

  // The newest row is written with the incoming word while the old entry is read out.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      prev_rd_r        <= prev_mem[rd_addr];
      prev_mem[rd_addr] <= wr_px;
    end
  end

  // The older row takes the middle value once the word leaves the window stage.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      prev2_rd_r <= prev2_mem[rd_addr];
    end
    if (wb_en) begin
      prev2_mem[wb_addr] <= prev_rd_r;
    end
  end

  // A read that lands on the entry being written back in the same cycle
  // would see stale data, so the write-back value is captured instead.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_r    <= wb_en && (wb_addr == rd_addr);
      fwd_px_r <= prev_rd_r;
    end
  end

  assign top_px = fwd_r ? fwd_px_r : prev2_rd_r;
  assign mid_px = prev_rd_r;

endmodule

// File: hdl/rbb_window.sv
// Two-column pixel window and the masked 3x3 channel sums.
module rbb_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  rbb_pkg::pixel_t   col_top,
  input  rbb_pkg::pixel_t   col_mid,
  input  rbb_pkg::pixel_t   col_bot,
  input  rbb_pkg::nbr_t     nbr,
  output rbb_pkg::sum_t     sums
);

  localparam int unsigned SUM_W = rbb_pkg::SUM_W;
  localparam int unsigned CH_W  = rbb_pkg::CH_W;

  // Entries 0..2 are the older column (top, middle, bottom), 3..5 the newer one.
  rbb_pkg::pixel_t win_r [6];
  rbb_pkg::pixel_t newcol [3];

  assign newcol[0] = col_top;
  assign newcol[1] = col_mid;
  assign newcol[2] = col_bot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i]     <= win_r[i + 3];
        win_r[i + 3] <= newcol[i];
      end
    end
  end

  always_comb begin
    rbb_pkg::pixel_t  px;
    logic             keep;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    red   = '0;
    green = '0;
    blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px   = (c == 2) ? newcol[r] : win_r[c * 3 + r];
        keep = !((r == 0 && !nbr.up) || (r == 2 && !nbr.down) ||
                 (c == 0 && !nbr.left) || (c == 2 && !nbr.right));
        if (keep) begin
          red   = red   + SUM_W'(px[3*CH_W-1:2*CH_W]);
          green = green + SUM_W'(px[2*CH_W-1:CH_W]);
          blue  = blue  + SUM_W'(px[CH_W-1:0]);
        end
      end
    end
    sums.red       = red;
    sums.green     = green;
    sums.blue      = blue;
    sums.frame_end = nbr.frame_end;
    if ((nbr.up && nbr.down) && (nbr.left && nbr.right)) begin
      sums.cnt = rbb_pkg::CNT_NINE;
    end else if ((nbr.up && nbr.down) || (nbr.left && nbr.right)) begin
      sums.cnt = rbb_pkg::CNT_SIX;
    end else begin
      sums.cnt = rbb_pkg::CNT_FOUR;
    end
  end

endmodule

// File: hdl/rbb_divide.sv
// Sum register, division by the neighbor count and the output register.
module rbb_divide (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              offer,
  input  rbb_pkg::sum_t     sums,
  output logic              take_ready,
  rbb_out_if.source         out_if
);

  localparam int unsigned SUM_W       = rbb_pkg::SUM_W;
  localparam int unsigned CH_W        = rbb_pkg::CH_W;
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned PROD_W      = SUM_W + RECIP_SHIFT;
  // Rounded-up reciprocals; exact for every sum that nine 8-bit values can reach.
  localparam logic [RECIP_SHIFT-1:0] RECIP_SIX  = RECIP_SHIFT'((2 ** RECIP_SHIFT + 5) / 6);
  localparam logic [RECIP_SHIFT-1:0] RECIP_NINE = RECIP_SHIFT'((2 ** RECIP_SHIFT + 8) / 9);

  function automatic logic [CH_W-1:0] div_count(input logic [SUM_W-1:0] sum,
                                                input rbb_pkg::cnt_code_t cnt);
    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   q;
    prod = '0;
    q    = '0;
    unique case (cnt)
      rbb_pkg::CNT_FOUR: q = CH_W'(sum >> 2);
      rbb_pkg::CNT_SIX: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP_SIX);
        q    = CH_W'(prod >> RECIP_SHIFT);
      end
      rbb_pkg::CNT_NINE: begin
        prod = PROD_W'(sum) * PROD_W'(RECIP_NINE);
        q    = CH_W'(prod >> RECIP_SHIFT);
      end
      default: q = '0;
    endcase
    return q;
  endfunction

  rbb_pkg::sum_t   s2_r;
  logic            s2_valid_r;
  logic            out_valid_r;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;
  logic            frame_end_r;
  logic            out_free;
  logic            out_load;

  assign out_free   = !out_valid_r || out_if.ready;
  assign take_ready = !s2_valid_r || out_free;
  assign out_load   = s2_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (offer && take_ready) begin
        s2_valid_r <= 1'b1;
      end else if (out_free) begin
        s2_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (offer && take_ready) begin
      s2_r <= sums;
    end
    if (out_load) begin
      red_r       <= div_count(s2_r.red, s2_r.cnt);
      green_r     <= div_count(s2_r.green, s2_r.cnt);
      blue_r      <= div_count(s2_r.blue, s2_r.cnt);
      frame_end_r <= s2_r.frame_end;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.blur_red   = red_r;
  assign out_if.blur_green = green_r;
  assign out_if.blur_blue  = blue_r;
  assign out_if.frame_end  = frame_end_r;

endmodule

// File: hdl/rgb_box_blur_3x3_core.sv
// Streaming 3x3 box blur of RGB words with edge-aware averaging, top level.
// A word is taken in every cycle while the output side does not stall; the result it
// releases reaches the output register one row plus one word behind the input stream.
// The stages are the line-memory read, the window sum and the divide into the output register.
// Synchronous active-low reset clears the counters, window and stage valids and sets the
// size registers to 640 x 480; the line memories keep their contents and need no clearing.
module rgb_box_blur_3x3_core #(
  parameter int unsigned MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rbb_in_if.sink     in_if,
  rbb_out_if.source  out_if,
  rbb_cfg_if.sink    cfg_if
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WSIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSIZE_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned IROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned CFG_W   = rbb_pkg::CFG_W;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned maxv);
    int unsigned val;
    val = 32'(v);
    if (val < 32'd2) begin
      return 32'd2;
    end
    if (val > maxv) begin
      return maxv;
    end
    return val;
  endfunction

  // Size registers
  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [WSIZE_W-1:0] w;
  logic [HSIZE_W-1:0] h;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbb_pkg::WIDTH_RESET;
      height_r <= rbb_pkg::HEIGHT_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        rbb_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_if.data;
        rbb_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign w = WSIZE_W'(clamp_size(width_r, MAX_WIDTH));
  assign h = HSIZE_W'(clamp_size(height_r, MAX_HEIGHT));

  // Position counters
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic            in_acc;
  logic            emit;
  rbb_pkg::pixel_t px;
  rbb_pkg::nbr_t   nbr;

  // Drain words, and any word once the last row is in, count as black.
  assign px = (in_if.mode != rbb_pkg::MODE_DRAIN && 32'(in_row_r) < 32'(h)) ?
              {in_if.pixel_red, in_if.pixel_green, in_if.pixel_blue} : '0;

  assign emit = (32'(in_row_r) >= 32'd2) || (32'(in_row_r) == 32'd1 && in_col_r != '0);

  assign nbr.up        = out_row_r != '0;
  assign nbr.down      = 32'(out_row_r) + 32'd1 < 32'(h);
  assign nbr.left      = out_col_r != '0;
  assign nbr.right     = 32'(out_col_r) + 32'd1 < 32'(w);
  assign nbr.frame_end = !nbr.down && !nbr.right;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_acc) begin
      if (32'(in_col_r) + 32'd1 >= 32'(w)) begin
        in_col_nxt = '0;
        if (32'(in_row_r) <= MAX_HEIGHT) begin
          in_row_nxt = in_row_r + IROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (nbr.frame_end) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (!nbr.right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Window stage: the word whose line-memory data is being read
  logic            s1_valid_r;
  logic            s1_emit_r;
  rbb_pkg::pixel_t s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  rbb_pkg::nbr_t   s1_nbr_r;
  logic            s1_leave;
  logic            take_ready;

  assign s1_leave    = s1_valid_r && (!s1_emit_r || take_ready);
  assign in_if.ready = !s1_valid_r || s1_leave;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_leave) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r <= emit;
      s1_px_r   <= px;
      s1_col_r  <= in_col_r;
      s1_nbr_r  <= nbr;
    end
  end

  rbb_pkg::pixel_t top_px;
  rbb_pkg::pixel_t mid_px;
  rbb_pkg::sum_t   sums;

  rbb_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_col_r),
    .wr_px   (px),
    .wb_en   (s1_leave),
    .wb_addr (s1_col_r),
    .top_px  (top_px),
    .mid_px  (mid_px)
  );

  rbb_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_leave),
    .col_top  (top_px),
    .col_mid  (mid_px),
    .col_bot  (s1_px_r),
    .nbr      (s1_nbr_r),
    .sums     (sums)
  );

  rbb_divide u_divide (
    .clk        (clk),
    .rst_n      (rst_n),
    .offer      (s1_valid_r && s1_emit_r),
    .sums       (sums),
    .take_ready (take_ready),
    .out_if     (out_if)
  );

endmodule

// File: hdl/rbb_checker.sv
// Port-level checker for the blur top level and its bind statement.
`include "assert_macros.svh"

module rbb_checker (
  input logic        clk,
  input logic        rst_n,
  rbb_in_if.sink     in_if,
  rbb_out_if.source  out_if
);

  // Nothing leaves the block in the cycle after a reset edge.
  `RBB_ASSERT_ALWAYS(a_out_idle_after_reset, clk, !rst_n |=> !out_if.valid)

  // With no word waiting at the output, the input side is never held off.
  `RBB_ASSERT_RUN(a_in_ready_when_out_empty, clk, rst_n, !out_if.valid |-> in_if.ready)

  // A stalled output word stays offered.
  `RBB_ASSERT_RUN(a_out_valid_holds, clk, rst_n, out_if.valid && !out_if.ready |=> out_if.valid)

  // A stalled output word keeps its value.
  `RBB_ASSERT_RUN(a_out_data_holds, clk, rst_n, out_if.valid && !out_if.ready |=> $stable(out_if.blur_red) && $stable(out_if.blur_green) && $stable(out_if.blur_blue) && $stable(out_if.frame_end))

endmodule

bind rgb_box_blur_3x3_core rbb_checker u_rbb_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);

// File: test/rgb_box_blur_3x3_core_tb.sv
// Self-checking testbench for the streaming 3x3 RGB box blur with edge-aware averaging.
module rgb_box_blur_3x3_core_tb;

  localparam int unsigned CH_W          = rbb_pkg::CH_W;
  localparam int unsigned CFG_W         = rbb_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W     = rbb_pkg::CFG_IDX_W;
  localparam int unsigned MAX_W         = rbb_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_H         = rbb_pkg::MAX_HEIGHT_DEF;
  localparam logic        MODE_DRAIN    = rbb_pkg::MODE_DRAIN;
  localparam logic        MODE_PIXEL    = ~rbb_pkg::MODE_DRAIN;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_WORDS  = 1150;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbb_in_if  in_if();
  rbb_out_if out_if();
  rbb_cfg_if cfg_if();

  rgb_box_blur_3x3_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #4 clk = ~clk;

  // Shadow of the block: line stores, window and raster counters.
  rbb_pkg::pixel_t row_above  [MAX_W] = '{default: '0};
  rbb_pkg::pixel_t row_above2 [MAX_W] = '{default: '0};
  rbb_pkg::pixel_t window_px  [6]     = '{default: '0};
  int unsigned     in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  logic [CFG_W-1:0] width_reg  = rbb_pkg::WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = rbb_pkg::HEIGHT_RESET;

  pix_word_t   pixels_to_send [$];
  blur_word_t  blurred_due [$];

  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          drv_busy = 1'b0;
  pix_word_t   drv_item = '0;
  int unsigned drv_wait = 0;
  int unsigned rcv_wait = 0;
  int unsigned rcv_hold = 0;
  int unsigned quiet_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned words_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned frames_queued = 0;

  function automatic int unsigned size_used(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v < 2) return 2;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned next_gap(input bit on);
    return on ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic logic [CH_W-1:0] rand_ch();
    return CH_W'($urandom_range(0, 255));
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  // Advances the shadow by one accepted word and queues the blurred word it releases.
  function automatic void blur_predict(input pix_word_t item);
    int unsigned     w, h, cnt, sum_r, sum_g, sum_b, r, c, k;
    rbb_pkg::pixel_t px, tap;
    rbb_pkg::pixel_t col_new [3];
    logic            up, down, left, right, emit;
    blur_word_t      res;
    w = size_used(width_reg, MAX_W);
    h = size_used(height_reg, MAX_H);
    px = '0;
    if (item.mode != MODE_DRAIN && in_row < h) px = {item.red, item.green, item.blue};
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    col_new[0] = '0;
    col_new[1] = '0;
    if (in_col < MAX_W) begin
      col_new[0] = row_above2[in_col];
      col_new[1] = row_above[in_col];
      row_above2[in_col] = col_new[1];
      row_above[in_col] = px;
    end
    col_new[2] = px;
    res = '0;
    if (emit) begin
      up = out_row > 0;
      down = out_row + 1 < h;
      left = out_col > 0;
      right = out_col + 1 < w;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt = 0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          if (!((r == 0 && !up) || (r == 2 && !down) || (c == 0 && !left) ||
                (c == 2 && !right))) begin
            tap = (c == 2) ? col_new[r] : window_px[c * 3 + r];
            sum_r += 32'(tap[2*CH_W +: CH_W]);
            sum_g += 32'(tap[CH_W +: CH_W]);
            sum_b += 32'(tap[0 +: CH_W]);
            cnt++;
          end
        end
      end
      res.red = CH_W'(sum_r / cnt);
      res.green = CH_W'(sum_g / cnt);
      res.blue = CH_W'(sum_b / cnt);
      res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
      blurred_due.push_back(res);
    end
    for (k = 0; k < 3; k++) begin
      window_px[k] = window_px[k + 3];
      window_px[k + 3] = col_new[k];
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row <= MAX_H) in_row++;
    end else begin
      in_col++;
    end
    if (emit) begin
      if (res.frame_end) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endfunction

  function automatic void push_word(input logic mode, input logic [CH_W-1:0] r,
                                    input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    pix_word_t item;
    item.mode = mode;
    item.red = r;
    item.green = g;
    item.blue = b;
    pixels_to_send.push_back(item);
  endfunction

  // Queues one frame at the current sizes; noise is the percent of words with the other mode.
  function automatic int unsigned queue_frame(input int unsigned noise);
    int unsigned w, h, i;
    w = size_used(width_reg, MAX_W);
    h = size_used(height_reg, MAX_H);
    for (i = 0; i < w * h; i++)
      push_word(($urandom_range(0, 99) < noise) ? MODE_DRAIN : MODE_PIXEL,
                rand_ch(), rand_ch(), rand_ch());
    for (i = 0; i <= w; i++)
      push_word(($urandom_range(0, 99) < noise) ? MODE_PIXEL : MODE_DRAIN,
                rand_ch(), rand_ch(), rand_ch());
    frames_queued++;
    return w * h + w + 1;
  endfunction

  // Waits until every queued word is in and every blurred word is out, then lets the
  // pipeline settle so that a word with no result is surely finished too.
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || drv_busy || blurred_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == rbb_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    reg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // Pixel driver: one word in flight, a random gap, when enabled, after each accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.mode <= MODE_PIXEL;
      in_if.pixel_red <= '0;
      in_if.pixel_green <= '0;
      in_if.pixel_blue <= '0;
      drv_busy = 1'b0;
      drv_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        blur_predict(drv_item);
        words_accepted++;
        drv_busy = 1'b0;
        drv_wait = next_gap(send_idle);
      end
      if (!drv_busy) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (pixels_to_send.size() != 0) begin
          drv_item = pixels_to_send.pop_front();
          drv_busy = 1'b1;
        end
      end
      in_if.valid <= drv_busy;
      in_if.mode <= drv_item.mode;
      in_if.pixel_red <= drv_item.red;
      in_if.pixel_green <= drv_item.green;
      in_if.pixel_blue <= drv_item.blue;
    end
  end

  // Result monitor: checks each blurred word and stalls the output at random. Twice in
  // the run it holds ready low for a long stretch so that the block backs up.
  always @(posedge clk) begin : monitor
    blur_word_t want;
    bit         rdy;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (blurred_due.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want = blurred_due.pop_front();
          if (out_if.blur_red !== want.red)
            report_error($sformatf("result %0d red: got %0d expected %0d",
                                   results_checked, out_if.blur_red, want.red));
          if (out_if.blur_green !== want.green)
            report_error($sformatf("result %0d green: got %0d expected %0d",
                                   results_checked, out_if.blur_green, want.green));
          if (out_if.blur_blue !== want.blue)
            report_error($sformatf("result %0d blue: got %0d expected %0d",
                                   results_checked, out_if.blur_blue, want.blue));
          if (out_if.frame_end !== want.frame_end)
            report_error($sformatf("result %0d frame_end: got %0b expected %0b",
                                   results_checked, out_if.frame_end, want.frame_end));
        end
        results_checked++;
        if (results_checked == 40 || results_checked == 900) rcv_hold = HOLD_CYCLES;
        else rcv_wait = next_gap(recv_idle);
      end
      rdy = (rcv_hold == 0) && (rcv_wait == 0);
      if (rcv_hold > 0) rcv_hold--;
      else if (rcv_wait > 0) rcv_wait--;
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results still expected",
                 quiet_cycles, blurred_due.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned random_words, rw, rh, noise, left_over;
    cfg_if.valid = 1'b0;
    cfg_if.index = rbb_pkg::REG_IMAGE_WIDTH;
    cfg_if.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame, sizes below range; corner averages of full-scale and zero channels.
    write_reg(rbb_pkg::REG_IMAGE_WIDTH, CFG_W'(0));
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(1));
    push_word(MODE_PIXEL, 8'hff, 8'h00, 8'hff);
    push_word(MODE_PIXEL, 8'h00, 8'hff, 8'h00);
    push_word(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
    push_word(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
    repeat (3) push_word(MODE_DRAIN, 8'hff, 8'hff, 8'hff);
    frames_queued++;

    // A drain tick among the pixels reads as black; a pixel during the drain is ignored.
    push_word(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
    push_word(MODE_DRAIN, 8'hff, 8'hff, 8'hff);
    push_word(MODE_PIXEL, 8'h80, 8'h7f, 8'h01);
    push_word(MODE_PIXEL, 8'hfe, 8'h02, 8'hff);
    push_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
    push_word(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
    push_word(MODE_DRAIN, 8'h55, 8'haa, 8'h55);
    frames_queued++;

    // Height shrinks in the middle of a frame; drain ticks then finish the shorter frame.
    wait_idle();
    write_reg(rbb_pkg::REG_IMAGE_WIDTH, CFG_W'(3));
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(4));
    repeat (6) push_word(MODE_PIXEL, rand_ch(), rand_ch(), rand_ch());
    wait_idle();
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(2));
    left_over = (size_used(height_reg, MAX_H) - 1 - out_row) * size_used(width_reg, MAX_W)
                + (size_used(width_reg, MAX_W) - 1 - out_col) + 1;
    repeat (left_over) push_word(MODE_DRAIN, rand_ch(), rand_ch(), rand_ch());
    frames_queued++;

    // A larger frame sent with no gaps; the first long output stall lands here.
    wait_idle();
    send_idle = 1'b0;
    write_reg(rbb_pkg::REG_IMAGE_WIDTH, CFG_W'(32));
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(16));
    void'(queue_frame(0));
    wait_idle();
    recv_idle = 1'b0;
    write_reg(rbb_pkg::REG_IMAGE_WIDTH, CFG_W'(24));
    write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(12));
    void'(queue_frame(5));

    // Random small frames, mostly well formed, some with stray modes, some back to back.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) begin
        wait_idle();
        rw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 16);
        rh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        write_reg(rbb_pkg::REG_IMAGE_WIDTH, CFG_W'(rw));
        write_reg(rbb_pkg::REG_IMAGE_HEIGHT, CFG_W'(rh));
      end
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      noise = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 20) : 0;
      random_words += queue_frame(noise);
    end

    wait_idle();
    $display("Run covered %0d frames from 2x2 up to 32 wide and 16 tall, %0d words in,",
             frames_queued, words_accepted);
    $display("%0d blurred words checked, %0d register writes, %0d mismatches.",
             results_checked, reg_writes, mismatches);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
